// ===== rtl/mwalu_pkg.sv =====
// Package with the operation codes and shared types of the multiword ALU.
`default_nettype none
package mwalu_pkg;
    typedef enum logic [3:0] {
        MODE_EQ  = 4'd0,
        MODE_NE  = 4'd1,
        MODE_GT  = 4'd2,
        MODE_GE  = 4'd3,
        MODE_LT  = 4'd4,
        MODE_LE  = 4'd5,
        MODE_AND = 4'd6,
        MODE_OR  = 4'd7,
        MODE_NOT = 4'd8,
        MODE_XOR = 4'd9,
        MODE_SHR = 4'd10,
        MODE_SHL = 4'd11,
        MODE_ADD = 4'd12,
        MODE_SUB = 4'd13,
        MODE_MUL = 4'd14,
        MODE_NOP = 4'd15
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_MUL,
        ST_EMIT,
        ST_CLEAR
    } t_exec_state;

    localparam int unsigned IO_BITS = 32;
    localparam int unsigned AMT_BITS = 9;
endpackage
`default_nettype wire

// ===== rtl/mwalu_front.sv =====
// Front part: collects operand limbs and hands complete operations to the back part.
`default_nettype none
module mwalu_front
    import mwalu_pkg::*;
#(
    parameter int LIMBS = 8,
    parameter int LIMB_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [3:0]           i_mode,
    input  wire logic [IO_BITS-1:0]   i_a_limb,
    input  wire logic [IO_BITS-1:0]   i_b_limb,
    input  wire logic [AMT_BITS-1:0]  i_shift_amount,
    input  wire logic                 i_last_limb,
    // Hand-off of a complete operation.
    output logic                      o_op_valid,
    input  wire logic                 i_op_ready,
    output t_mode                     o_op_mode,
    output logic [AMT_BITS-1:0]       o_op_amount,
    output logic [LIMBS*LIMB_BITS-1:0] o_op_a,
    output logic [LIMBS*LIMB_BITS-1:0] o_op_b
);
    localparam int CW = $clog2(LIMBS + 1);

    logic [LIMB_BITS-1:0] r_a [LIMBS];
    logic [LIMB_BITS-1:0] r_b [LIMBS];
    logic [CW-1:0]        r_cnt;
    logic                 r_pend;
    t_mode                r_mode;
    logic [AMT_BITS-1:0]  r_amt;
    logic                 w_acc;

    // The single-entry queue: the operand stores hold while a job waits.
    assign o_ready = !r_pend;
    assign w_acc   = i_valid && o_ready;
    assign o_op_valid  = r_pend;
    assign o_op_mode   = r_mode;
    assign o_op_amount = r_amt;

    always_comb begin
        for (int k = 0; k < LIMBS; k++) begin
            o_op_a[k*LIMB_BITS +: LIMB_BITS] = r_a[k];
            o_op_b[k*LIMB_BITS +: LIMB_BITS] = r_b[k];
        end
    end

    // Limb capture, counter and clear after hand-off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pend <= 1'b0;
            for (int k = 0; k < LIMBS; k++) begin
                r_a[k] <= '0;
                r_b[k] <= '0;
            end
        end else begin
            if (r_pend && i_op_ready) begin
                r_pend <= 1'b0;
                r_cnt  <= '0;
                for (int k = 0; k < LIMBS; k++) begin
                    r_a[k] <= '0;
                    r_b[k] <= '0;
                end
            end
            if (w_acc) begin
                if (r_cnt < CW'(LIMBS)) begin
                    r_a[r_cnt[$clog2(LIMBS)-1:0]] <= i_a_limb[LIMB_BITS-1:0];
                    r_b[r_cnt[$clog2(LIMBS)-1:0]] <= i_b_limb[LIMB_BITS-1:0];
                    r_cnt <= r_cnt + 1'b1;
                end
                if (i_last_limb) begin
                    r_pend <= 1'b1;
                    r_mode <= t_mode'(i_mode);
                    r_amt  <= i_shift_amount;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/mwalu_back.sv =====
// Back part: runs the operation limb by limb and emits result items.
`default_nettype none
module mwalu_back
    import mwalu_pkg::*;
#(
    parameter int LIMBS = 8,
    parameter int LIMB_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_op_valid,
    output logic                       o_op_ready,
    input  wire t_mode                 i_op_mode,
    input  wire logic [AMT_BITS-1:0]   i_op_amount,
    input  wire logic [LIMBS*LIMB_BITS-1:0] i_op_a,
    input  wire logic [LIMBS*LIMB_BITS-1:0] i_op_b,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [IO_BITS-1:0]         o_result_limb,
    output logic                       o_compare_flag,
    output logic                       o_last_result
);
    localparam int LW    = $clog2(LIMBS);
    localparam int TOTAL = LIMBS * LIMB_BITS;
    localparam int RW    = $clog2(LIMB_BITS);
    localparam int CNTW  = $clog2(2 * LIMBS + 1);

    t_exec_state          r_st, n_st;
    t_mode                r_mode;
    logic [AMT_BITS-1:0]  r_amt;
    logic [LIMB_BITS-1:0] r_a [LIMBS];
    logic [LIMB_BITS-1:0] r_b [LIMBS];
    logic [LIMB_BITS-1:0] r_p [LIMBS];
    logic [CNTW-1:0]      r_mc [LIMBS];
    logic [LW-1:0]        r_i, r_j, r_k;
    logic                 r_c;
    logic [1:0]           r_cmp;       // 1 greater, 2 less, 0 equal
    logic                 r_ov;
    logic [IO_BITS-1:0]   r_olimb;
    logic                 r_oflag, r_olast;

    // Multiply: one limb product per cycle. The low half is added into its
    // column and the high half into the next one; each carry out is counted
    // in the column above and folded in while the result limbs are emitted.
    logic [2*LIMB_BITS-1:0] w_prod;
    logic [LW:0]            w_col;
    logic [LW-1:0]          w_col_lo, w_col_hi, w_col_c2;
    logic                   w_has_hi, w_has_c2;
    logic [LIMB_BITS:0]     w_s0, w_s1;
    assign w_prod   = r_a[r_j] * r_b[r_i];
    assign w_col    = (LW+1)'(r_i) + (LW+1)'(r_j);
    assign w_col_lo = w_col[LW-1:0];
    assign w_col_hi = LW'(w_col + (LW+1)'(1));
    assign w_col_c2 = LW'(w_col + (LW+1)'(2));
    assign w_has_hi = (int'(w_col) + 1 < LIMBS);
    assign w_has_c2 = (int'(w_col) + 2 < LIMBS);
    assign w_s0 = {1'b0, r_p[w_col_lo]} + {1'b0, w_prod[LIMB_BITS-1:0]};
    assign w_s1 = {1'b0, r_p[w_col_hi]} + {1'b0, w_prod[2*LIMB_BITS-1:LIMB_BITS]};

    // Shift source limbs and result of limb k for the other modes.
    logic [LIMB_BITS-1:0] w_v;
    logic                 w_cn;
    always_comb begin
        logic [AMT_BITS-1:0] full;
        logic [RW-1:0]       r;
        logic [2*LIMB_BITS-1:0] pair;
        logic [LIMB_BITS:0]  s;
        int                  idx;
        full = AMT_BITS'(r_amt / LIMB_BITS);
        r    = RW'(r_amt % LIMB_BITS);
        pair = '0;
        s    = '0;
        w_v  = '0;
        w_cn = 1'b0;
        idx  = 0;
        case (r_mode)
            MODE_AND: w_v = r_a[r_k] & r_b[r_k];
            MODE_OR:  w_v = r_a[r_k] | r_b[r_k];
            MODE_NOT: w_v = ~r_a[r_k];
            MODE_XOR: w_v = r_a[r_k] ^ r_b[r_k];
            MODE_SHR: begin
                idx = int'(r_k) + int'(full);
                if (idx < LIMBS) pair[LIMB_BITS-1:0] = r_a[LW'(idx)];
                if (idx + 1 < LIMBS) pair[2*LIMB_BITS-1:LIMB_BITS] = r_a[LW'(idx + 1)];
                pair = pair >> r;
                if (int'(r_amt) < TOTAL) w_v = pair[LIMB_BITS-1:0];
            end
            MODE_SHL: begin
                idx = int'(r_k) - int'(full);
                if (idx >= 0 && idx < LIMBS) pair[2*LIMB_BITS-1:LIMB_BITS] = r_a[LW'(idx)];
                if (idx - 1 >= 0 && idx - 1 < LIMBS) pair[LIMB_BITS-1:0] = r_a[LW'(idx - 1)];
                pair = pair << r;
                if (int'(r_amt) < TOTAL) w_v = pair[2*LIMB_BITS-1:LIMB_BITS];
            end
            MODE_ADD: begin
                s = {1'b0, r_a[r_k]} + {1'b0, r_b[r_k]} + {{LIMB_BITS{1'b0}}, r_c};
                w_v = s[LIMB_BITS-1:0];
                w_cn = s[LIMB_BITS];
            end
            MODE_SUB: begin
                s = {1'b0, r_a[r_k]} - {1'b0, r_b[r_k]} - {{LIMB_BITS{1'b0}}, r_c};
                w_v = s[LIMB_BITS-1:0];
                w_cn = s[LIMB_BITS];
            end
            MODE_MUL: begin
                s = {1'b0, r_p[r_k]} + (LIMB_BITS+1)'(r_mc[r_k])
                    + {{LIMB_BITS{1'b0}}, r_c};
                w_v = s[LIMB_BITS-1:0];
                w_cn = s[LIMB_BITS];
            end
            default:  w_v = '0;
        endcase
    end

    logic w_flag;
    always_comb begin
        unique case (r_mode)
            MODE_EQ: w_flag = r_cmp == 2'd0;
            MODE_NE: w_flag = r_cmp != 2'd0;
            MODE_GT: w_flag = r_cmp == 2'd1;
            MODE_GE: w_flag = r_cmp != 2'd2;
            MODE_LT: w_flag = r_cmp == 2'd2;
            default: w_flag = r_cmp != 2'd1;
        endcase
    end

    logic w_ofree;
    assign w_ofree = !r_ov || i_ready;
    assign o_op_ready = (r_st == ST_IDLE);
    assign o_valid = r_ov;
    assign o_result_limb = r_olimb;
    assign o_compare_flag = r_oflag;
    assign o_last_result = r_olast;

    // Next state of the sequencer.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (i_op_valid) begin
                if (i_op_mode <= MODE_LE) n_st = ST_CMP;
                else if (i_op_mode == MODE_MUL) n_st = ST_MUL;
                else if (i_op_mode == MODE_NOP) n_st = ST_IDLE;
                else n_st = ST_EMIT;
            end
            ST_CMP:  if (r_k == '0 || r_a[r_k] != r_b[r_k]) n_st = ST_CLEAR;
            ST_MUL:  if (r_i == LW'(LIMBS-1)) n_st = ST_EMIT;
            ST_EMIT: if (w_ofree && r_k == LW'(LIMBS-1)) n_st = ST_IDLE;
            ST_CLEAR: if (w_ofree) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else r_st <= n_st;
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    r_mode <= i_op_mode;
                    r_amt  <= i_op_amount;
                    r_i <= '0;
                    r_j <= '0;
                    r_c <= 1'b0;
                    r_cmp <= 2'd0;
                    r_k <= (i_op_mode <= MODE_LE) ? LW'(LIMBS-1) : '0;
                    for (int k = 0; k < LIMBS; k++) begin
                        r_a[k] <= i_op_a[k*LIMB_BITS +: LIMB_BITS];
                        r_b[k] <= i_op_b[k*LIMB_BITS +: LIMB_BITS];
                        r_p[k] <= '0;
                        r_mc[k] <= '0;
                    end
                end
                ST_CMP: begin
                    if (r_a[r_k] > r_b[r_k]) r_cmp <= 2'd1;
                    else if (r_a[r_k] < r_b[r_k]) r_cmp <= 2'd2;
                    r_k <= r_k - 1'b1;
                end
                ST_MUL: begin
                    r_p[w_col_lo] <= w_s0[LIMB_BITS-1:0];
                    if (w_has_hi) begin
                        r_p[w_col_hi]  <= w_s1[LIMB_BITS-1:0];
                        r_mc[w_col_hi] <= r_mc[w_col_hi] + CNTW'(w_s0[LIMB_BITS]);
                    end
                    if (w_has_c2) begin
                        r_mc[w_col_c2] <= r_mc[w_col_c2] + CNTW'(w_s1[LIMB_BITS]);
                    end
                    if (w_col >= (LW+1)'(LIMBS-1)) begin
                        r_j <= '0;
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                ST_EMIT: if (w_ofree) begin
                    r_ov <= 1'b1;
                    r_olimb <= IO_BITS'(w_v);
                    r_oflag <= 1'b0;
                    r_olast <= (r_k == LW'(LIMBS-1));
                    r_c <= w_cn;
                    r_k <= r_k + 1'b1;
                end
                ST_CLEAR: if (w_ofree) begin
                    r_ov <= 1'b1;
                    r_olimb <= '0;
                    r_oflag <= w_flag;
                    r_olast <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/multiword_integer_alu_top.sv =====
// Top level of the multiword integer ALU.
// Input channel: one item per operand limb pair, least significant first;
// the item with i_last_limb high also carries the mode and shift amount.
// Output channel: one item per result limb (LIMBS of them), or one item with
// the compare flag for compare modes and none for NOP; o_last_result marks the final item.
// Limbs load at one per cycle into the front stores. A finished operand set
// waits in the front stores until the back sequencer is idle, and limb loading
// stalls for as long as such a finished set is waiting.
// With the back idle, the last limb sets the front pending flag; the back
// takes the operands in ST_IDLE, walks ST_CMP for compare modes (starting at
// the top limb and stopping at the first difference) or ST_MUL for multiply
// on the single shared limb multiplier, and then fills the output register. Limb
// results then follow at one per cycle while the receiver is ready.
// Reset clears the front stores and the queue; nothing is emitted until new limbs
// arrive. When the receiver stalls, the output register holds and the back
// part waits; the front keeps taking limbs until the next operation is complete.
`default_nettype none
module multiword_integer_alu_top
    import mwalu_pkg::*;
#(
    parameter int LIMBS = 8,
    parameter int LIMB_BITS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [3:0]          i_mode,
    input  wire logic [IO_BITS-1:0]  i_a_limb,
    input  wire logic [IO_BITS-1:0]  i_b_limb,
    input  wire logic [AMT_BITS-1:0] i_shift_amount,
    input  wire logic                i_last_limb,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [IO_BITS-1:0]       o_result_limb,
    output logic                     o_compare_flag,
    output logic                     o_last_result
);
    logic                       w_op_valid, w_op_ready;
    t_mode                      w_op_mode;
    logic [AMT_BITS-1:0]        w_op_amount;
    logic [LIMBS*LIMB_BITS-1:0] w_op_a, w_op_b;

    // Operand collection.
    mwalu_front #(.LIMBS(LIMBS), .LIMB_BITS(LIMB_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_mode, .i_a_limb, .i_b_limb,
        .i_shift_amount, .i_last_limb,
        .o_op_valid(w_op_valid), .i_op_ready(w_op_ready), .o_op_mode(w_op_mode),
        .o_op_amount(w_op_amount), .o_op_a(w_op_a), .o_op_b(w_op_b)
    );

    // Execution.
    mwalu_back #(.LIMBS(LIMBS), .LIMB_BITS(LIMB_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_op_valid(w_op_valid), .o_op_ready(w_op_ready), .i_op_mode(w_op_mode),
        .i_op_amount(w_op_amount), .i_op_a(w_op_a), .i_op_b(w_op_b),
        .o_valid, .i_ready, .o_result_limb, .o_compare_flag, .o_last_result
    );
endmodule
`default_nettype wire

// ===== dv/tb_multiword_integer_alu_top.sv =====
// Self-checking testbench for the multiword integer ALU top level.
module tb_multiword_integer_alu_top;
    import mwalu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMBS = 8;
    localparam int LIMB_BITS = 32;
    localparam int TOTAL_BITS = LIMBS * LIMB_BITS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int STALL_CYCLES = 300;

    typedef logic [TOTAL_BITS-1:0] t_wide;

    // One input item and one result item.
    typedef struct packed {
        logic [3:0]          mode;
        logic [IO_BITS-1:0]  a_limb;
        logic [IO_BITS-1:0]  b_limb;
        logic [AMT_BITS-1:0] shift_amount;
        logic                last_limb;
    } t_limb_item;

    typedef struct packed {
        logic [IO_BITS-1:0] result_limb;
        logic               compare_flag;
        logic               last_result;
    } t_result_item;

    // A directed row: an operation given as whole operands.
    typedef struct {
        t_mode       mode;
        t_wide       a;
        t_wide       b;
        int          amt;
        int          nlimbs;
        bit          typed;
        logic [IO_BITS-1:0] want_limb0;
        bit          want_flag;
    } t_op_row;

    logic i_clk, i_rst_n;
    logic i_valid, o_ready;
    logic [3:0] i_mode;
    logic [IO_BITS-1:0] i_a_limb, i_b_limb;
    logic [AMT_BITS-1:0] i_shift_amount;
    logic i_last_limb;
    logic o_valid, i_ready;
    logic [IO_BITS-1:0] o_result_limb;
    logic o_compare_flag, o_last_result;

    multiword_integer_alu_top #(.LIMBS(LIMBS), .LIMB_BITS(LIMB_BITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_a_limb(i_a_limb), .i_b_limb(i_b_limb),
        .i_shift_amount(i_shift_amount), .i_last_limb(i_last_limb),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_result_limb(o_result_limb), .o_compare_flag(o_compare_flag),
        .o_last_result(o_last_result)
    );

    // Predictor state: operand stores and the limb counter.
    logic [LIMB_BITS-1:0] a_store [LIMBS];
    logic [LIMB_BITS-1:0] b_store [LIMBS];
    int limbs_loaded;

    t_result_item expected_results[$];
    t_limb_item   pending_items[$];
    int mismatches, cycle_count, ops_done, results_seen;
    bit idle_enable, hold_off;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic void clear_operands();
        for (int k = 0; k < LIMBS; k++) begin
            a_store[k] = '0;
            b_store[k] = '0;
        end
        limbs_loaded = 0;
    endfunction

    function automatic void push_result(logic [IO_BITS-1:0] limb, bit flag, bit last);
        t_result_item r;
        r.result_limb = limb;
        r.compare_flag = flag;
        r.last_result = last;
        expected_results.push_back(r);
    endfunction

    // Computes the results of one accepted limb item.
    function automatic void predict_limb(t_limb_item it);
        t_wide wa, wb, wr;
        logic [2*TOTAL_BITS-1:0] prod;
        bit flag;
        if (limbs_loaded < LIMBS) begin
            a_store[limbs_loaded] = it.a_limb;
            b_store[limbs_loaded] = it.b_limb;
            limbs_loaded++;
        end
        if (!it.last_limb) return;
        for (int k = 0; k < LIMBS; k++) begin
            wa[k*LIMB_BITS +: LIMB_BITS] = a_store[k];
            wb[k*LIMB_BITS +: LIMB_BITS] = b_store[k];
        end
        if (it.mode <= MODE_LE) begin
            case (t_mode'(it.mode))
                MODE_EQ: flag = wa == wb;
                MODE_NE: flag = wa != wb;
                MODE_GT: flag = wa > wb;
                MODE_GE: flag = wa >= wb;
                MODE_LT: flag = wa < wb;
                default: flag = wa <= wb;
            endcase
            push_result('0, flag, 1'b1);
        end else if (it.mode != MODE_NOP) begin
            case (t_mode'(it.mode))
                MODE_AND: wr = wa & wb;
                MODE_OR:  wr = wa | wb;
                MODE_NOT: wr = ~wa;
                MODE_XOR: wr = wa ^ wb;
                MODE_SHR: wr = (it.shift_amount >= TOTAL_BITS) ? '0 : wa >> it.shift_amount;
                MODE_SHL: wr = (it.shift_amount >= TOTAL_BITS) ? '0 : wa << it.shift_amount;
                MODE_ADD: wr = wa + wb;
                MODE_SUB: wr = wa - wb;
                default: begin
                    prod = {{TOTAL_BITS{1'b0}}, wa} * {{TOTAL_BITS{1'b0}}, wb};
                    wr = prod[TOTAL_BITS-1:0];
                end
            endcase
            for (int k = 0; k < LIMBS; k++)
                push_result(wr[k*LIMB_BITS +: LIMB_BITS], 1'b0, k == LIMBS - 1);
        end
        ops_done++;
        clear_operands();
    endfunction

    // Splits one operation into limb items.
    function automatic void queue_op(t_mode mode, t_wide a, t_wide b, int amt, int nlimbs);
        t_limb_item it;
        for (int k = 0; k < nlimbs; k++) begin
            it.mode = (k == nlimbs - 1) ? mode : 4'($urandom_range(0, 15));
            it.a_limb = (k < LIMBS) ? a[k*LIMB_BITS +: LIMB_BITS] : $urandom;
            it.b_limb = (k < LIMBS) ? b[k*LIMB_BITS +: LIMB_BITS] : $urandom;
            it.shift_amount = (k == nlimbs - 1) ? AMT_BITS'(amt) : AMT_BITS'($urandom);
            it.last_limb = (k == nlimbs - 1);
            pending_items.push_back(it);
        end
    endfunction

    function automatic t_wide random_wide();
        t_wide w;
        int pick;
        pick = $urandom_range(0, 5);
        for (int k = 0; k < LIMBS; k++) w[k*32 +: 32] = $urandom;
        if (pick == 0) w = '0;
        else if (pick == 1) w = '1;
        else if (pick == 2) w = w >> $urandom_range(0, TOTAL_BITS - 1);
        return w;
    endfunction

    // Sender: drives pending items at the falling edge.
    task automatic send_all();
        while (pending_items.size() > 0) begin
            @(negedge i_clk);
            if (idle_enable && $urandom_range(0, 5) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            {i_mode, i_a_limb, i_b_limb, i_shift_amount, i_last_limb} <= pending_items[0];
            i_valid <= 1'b1;
            do @(posedge i_clk); while (!o_ready);
            predict_limb(pending_items.pop_front());
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // Receiver: random stall bursts, or a long hold-off when requested.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge i_clk);
                hold_off = 1'b0;
            end
            if (idle_enable && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Result checker at the rising edge.
    always @(posedge i_clk) begin
        t_result_item got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got.result_limb = o_result_limb;
            got.compare_flag = o_compare_flag;
            got.last_result = o_last_result;
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result item %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: limb exp %h got %h, flag exp %b got %b, last exp %b got %b",
                            want.result_limb, got.result_limb, want.compare_flag,
                            got.compare_flag, want.last_result, got.last_result);
                end
            end
        end
    end

    t_op_row rows[$];

    function automatic void add_row(t_mode m, t_wide a, t_wide b, int amt, int n,
                                    bit typed, logic [31:0] l0, bit f);
        t_op_row r;
        r.mode = m; r.a = a; r.b = b; r.amt = amt; r.nlimbs = n;
        r.typed = typed; r.want_limb0 = l0; r.want_flag = f;
        rows.push_back(r);
    endfunction

    initial begin
        t_wide ones, one;
        int kind;
        ones = '1;
        one = t_wide'(1);
        mismatches = 0; results_seen = 0; ops_done = 0;
        idle_enable = 1'b1; hold_off = 1'b0;
        i_valid = 1'b0; i_mode = '0; i_a_limb = '0; i_b_limb = '0;
        i_shift_amount = '0; i_last_limb = 1'b0;
        i_rst_n = 1'b0;
        clear_operands();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; typed rows are read off at a glance.
        add_row(MODE_EQ, '0, '0, 0, LIMBS, 1, '0, 1);
        add_row(MODE_NE, ones, ones, 0, LIMBS, 1, '0, 0);
        add_row(MODE_GT, ones, '0, 0, LIMBS, 1, '0, 1);
        add_row(MODE_GE, '0, ones, 0, LIMBS, 1, '0, 0);
        add_row(MODE_LT, one, t_wide'(2), 0, 1, 1, '0, 1);
        add_row(MODE_LE, ones, ones, 0, LIMBS, 1, '0, 1);
        add_row(MODE_AND, ones, ones, 0, LIMBS, 1, 32'hffffffff, 0);
        add_row(MODE_OR, '0, '0, 0, LIMBS, 1, '0, 0);
        add_row(MODE_NOT, '0, ones, 0, LIMBS, 1, 32'hffffffff, 0);
        add_row(MODE_XOR, ones, ones, 0, LIMBS, 1, '0, 0);
        add_row(MODE_SHR, ones, '0, 256, LIMBS, 1, '0, 0);
        add_row(MODE_SHL, ones, '0, 511, LIMBS, 1, '0, 0);
        add_row(MODE_SHL, ones, '0, 255, LIMBS, 0, '0, 0);
        add_row(MODE_SHR, ones, '0, 33, LIMBS, 0, '0, 0);
        add_row(MODE_ADD, ones, one, 0, LIMBS, 1, '0, 0);
        add_row(MODE_SUB, '0, one, 0, LIMBS, 1, 32'hffffffff, 0);
        add_row(MODE_MUL, ones, ones, 0, LIMBS, 0, '0, 0);
        add_row(MODE_MUL, '0, ones, 0, LIMBS, 1, '0, 0);
        add_row(MODE_ADD, t_wide'(5), t_wide'(7), 0, 3, 0, '0, 0);
        add_row(MODE_XOR, random_wide(), random_wide(), 0, 11, 0, '0, 0);
        add_row(MODE_NOP, ones, ones, 0, LIMBS, 0, '0, 0);
        add_row(MODE_EQ, '0, '0, 0, 1, 1, '0, 1);

        foreach (rows[i]) begin
            // Let earlier results drain so the head of the queue is this row.
            while (expected_results.size() > 0) @(posedge i_clk);
            queue_op(rows[i].mode, rows[i].a, rows[i].b, rows[i].amt, rows[i].nlimbs);
            send_all();
            if (rows[i].typed) begin
                while (expected_results.size() > 0 &&
                       (expected_results[0].result_limb !== rows[i].want_limb0 ||
                        expected_results[0].compare_flag !== rows[i].want_flag)) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Row %0d: predictor disagrees with table", i);
                    break;
                end
            end
        end

        // Long receiver hold-off while operations keep arriving.
        hold_off = 1'b1;
        for (int n = 0; n < 3; n++)
            queue_op(MODE_ADD, random_wide(), random_wide(), 0, LIMBS);
        send_all();

        // Random operations, mostly well-formed, some short or overlong.
        for (int n = 0; n < 2; n++) begin
            kind = $urandom_range(0, 9);
            if (n >= 1) idle_enable = 1'b0;
            queue_op(t_mode'($urandom_range(0, 15)), random_wide(), random_wide(),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(256, 511)
                                                 : $urandom_range(0, 255),
                     (kind == 0) ? $urandom_range(1, LIMBS - 1) :
                     (kind == 1) ? $urandom_range(LIMBS + 1, 12) : LIMBS);
            send_all();
        end

        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Ran %0d operations through all modes, with stalls; %0d result items checked.",
                 ops_done, results_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
